### src/assert_macros.svh
// Assertion macros for the centered window average RTL.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by an expected state in the next cycle.
`define CWA_ASSERT_NEXT(lbl, cond, post, msg) \
  `CWA_ASSERT(lbl, (cond) |=> (post), msg)

`endif

### src/cwa_pkg.sv
// Package for the centered window average block: sizes, payload structs, states.
// No dependencies; used by centered_window_average_top, the checker and the testbench.
package cwa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RADIUS  = 31;

  localparam int RadiusBits = $clog2(MAX_RADIUS + 1);
  localparam int WinBits    = RadiusBits + 1;
  localparam int HistDepth  = 2 ** WinBits;
  localparam int HistBits   = WinBits;
  localparam int SumBits    = SAMPLE_BITS + WinBits;
  localparam int CountBits  = WinBits + 1;
  localparam int AvgBits    = SAMPLE_BITS + 1;
  localparam int StepBits   = $clog2(SumBits);

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [StepBits-1:0]  LastStep = StepBits'(SumBits - 1);
  localparam logic signed [AvgBits-1:0] AvgNone = '1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   final_sample;
  } in_t;

  typedef struct packed {
    logic signed [AvgBits-1:0] average;
    logic                      end_of_run;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT,
    ST_TAIL
  } state_e;

endpackage

### src/cwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sample delay line of the window average block.
module cwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/centered_window_average_top.sv
// Top level of the centered window average block.
// Depends on cwa_pkg, cwa_ram and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one sample and
//   an end-of-array flag per transfer. Output channel (out_valid_o /
//   out_stall_i / out_data_o) carries averages; -1 marks positions whose
//   window is incomplete, end_of_run flags the last result of an array.
//   The radius is written through cfg_valid_i / cfg_ready_o / cfg_data_i
//   while the block is idle; the window holds 2*radius+1 samples.
// Sequence:
//   A sample whose window is complete passes through a fetch from the delay
//   line RAM, the sum update, a bit-serial restoring divider giving one
//   quotient bit per cycle over the 22-bit sum, then the load of the output
//   register, which waits while the receiver stalls. Samples giving -1 skip
//   the divider and samples giving no result end after the sum update; the
//   final sample adds one output-register load per trailing -1 result.
// Reset clears the radius, sum, position count and write pointer; the delay
// line is not cleared. A stalled receiver holds the output register; the
// block stalls its input in every state but idle, also while it waits to load it.
`include "assert_macros.svh"

module centered_window_average_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cwa_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cwa_pkg::out_t                       out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cwa_pkg::RadiusBits-1:0]      cfg_data_i
);

  cwa_pkg::state_e state_q, state_d;

  logic [cwa_pkg::RadiusBits-1:0]  radius_q;
  logic [cwa_pkg::SAMPLE_BITS-1:0] smp_q;
  logic                            fin_q;
  logic [cwa_pkg::SumBits-1:0]     sum_q, sum_d;
  logic [cwa_pkg::CountBits-1:0]   count_q, count_d;
  logic [cwa_pkg::HistBits-1:0]    wp_q, wp_d;
  logic [cwa_pkg::RadiusBits-1:0]  tail_q, tail_d;
  logic [cwa_pkg::SumBits-1:0]     div_q, div_d;
  logic [cwa_pkg::WinBits-1:0]     rem_q, rem_d;
  logic [cwa_pkg::StepBits-1:0]    step_q, step_d;
  logic                            none_q, none_d;
  logic                            out_valid_q, out_valid_d;
  cwa_pkg::out_t                   out_data_q, out_data_d;

  logic [cwa_pkg::WinBits-1:0]     win;
  logic [cwa_pkg::WinBits-1:0]     two_k;
  logic [cwa_pkg::HistBits-1:0]    rd_addr;
  logic [cwa_pkg::SAMPLE_BITS-1:0] rd_data;
  logic                            hist_we;
  logic                            out_free;
  logic                            in_xfer;
  logic [cwa_pkg::SumBits-1:0]     sum_add;
  logic [cwa_pkg::SumBits-1:0]     old_smp;
  logic [cwa_pkg::CountBits:0]     n_items;
  logic [cwa_pkg::WinBits:0]       rem_shift;
  logic                            q_bit;
  logic signed [cwa_pkg::AvgBits-1:0] avg_sat;

  // Window geometry from the live radius
  assign win     = {radius_q, 1'b1};
  assign two_k   = {radius_q, 1'b0};
  assign rd_addr = wp_q - win;
  assign hist_we = (state_q == cwa_pkg::ST_UPDATE);

  // Handshakes
  assign in_stall_o  = (state_q != cwa_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == cwa_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  cwa_ram #(
    .WIDTH (cwa_pkg::SAMPLE_BITS),
    .DEPTH (cwa_pkg::HistDepth)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (hist_we),
    .wr_addr_i (wp_q),
    .wr_data_i (smp_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Running sum: add the new sample, drop the one leaving the window
  assign old_smp = (count_q >= cwa_pkg::CountBits'(win))
                   ? cwa_pkg::SumBits'(rd_data) : '0;
  assign sum_add = sum_q + cwa_pkg::SumBits'(smp_q) - old_smp;
  assign n_items = {1'b0, count_q} + 1'b1;

  // One restoring divider step
  assign rem_shift = {rem_q, div_q[cwa_pkg::SumBits-1]};
  assign q_bit     = (rem_shift >= {1'b0, win});

  // Saturate the quotient to the sample range
  assign avg_sat = (div_q[cwa_pkg::SumBits-1:cwa_pkg::SAMPLE_BITS] != '0)
                   ? cwa_pkg::AvgBits'({cwa_pkg::SAMPLE_BITS{1'b1}})
                   : cwa_pkg::AvgBits'(div_q[cwa_pkg::SAMPLE_BITS-1:0]);

  // Hold the state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cwa_pkg::ST_IDLE;
      radius_q    <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      wp_q        <= '0;
      tail_q      <= '0;
      step_q      <= '0;
      none_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      wp_q        <= wp_d;
      tail_q      <= tail_d;
      step_q      <= step_d;
      none_q      <= none_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q <= in_data_i.sample;
      fin_q <= in_data_i.final_sample;
    end
    div_q      <= div_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    wp_d        = wp_q;
    tail_d      = tail_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    none_d      = none_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      cwa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = cwa_pkg::ST_FETCH;
        end
      end

      cwa_pkg::ST_FETCH: begin
        state_d = cwa_pkg::ST_UPDATE;
      end

      cwa_pkg::ST_UPDATE: begin
        // Trailing -1 count for the end of the array
        tail_d = (n_items < (cwa_pkg::CountBits + 1)'(radius_q))
                 ? cwa_pkg::RadiusBits'(n_items) : radius_q;
        if (fin_q) begin
          sum_d   = '0;
          count_d = '0;
          wp_d    = '0;
        end else begin
          sum_d   = sum_add;
          count_d = (count_q == cwa_pkg::CountMax) ? count_q : count_q + 1'b1;
          wp_d    = wp_q + 1'b1;
        end
        div_d  = sum_add;
        rem_d  = '0;
        step_d = '0;
        if (count_q >= cwa_pkg::CountBits'(two_k)) begin
          none_d  = 1'b0;
          state_d = cwa_pkg::ST_DIVIDE;
        end else if (count_q >= cwa_pkg::CountBits'(radius_q)) begin
          none_d  = 1'b1;
          state_d = cwa_pkg::ST_EMIT;
        end else if (fin_q) begin
          state_d = cwa_pkg::ST_TAIL;
        end else begin
          state_d = cwa_pkg::ST_IDLE;
        end
      end

      cwa_pkg::ST_DIVIDE: begin
        // Shift in one dividend bit, subtract the window length if it fits
        rem_d  = q_bit ? cwa_pkg::WinBits'(rem_shift - {1'b0, win})
                       : cwa_pkg::WinBits'(rem_shift);
        div_d  = {div_q[cwa_pkg::SumBits-2:0], q_bit};
        step_d = step_q + 1'b1;
        if (step_q == cwa_pkg::LastStep) begin
          state_d = cwa_pkg::ST_EMIT;
        end
      end

      cwa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.average    = none_q ? cwa_pkg::AvgNone : avg_sat;
          out_data_d.end_of_run = fin_q && (tail_q == '0);
          state_d = (fin_q && (tail_q != '0)) ? cwa_pkg::ST_TAIL : cwa_pkg::ST_IDLE;
        end
      end

      cwa_pkg::ST_TAIL: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.average    = cwa_pkg::AvgNone;
          out_data_d.end_of_run = (tail_q == cwa_pkg::RadiusBits'(1));
          tail_d                = tail_q - 1'b1;
          if (tail_q == cwa_pkg::RadiusBits'(1)) begin
            state_d = cwa_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = cwa_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  `CWA_ASSERT(a_rem_bound, (state_q != cwa_pkg::ST_DIVIDE) || (rem_q < win),
              "divider remainder out of range")
  `CWA_ASSERT(a_tail_nonzero, (state_q != cwa_pkg::ST_TAIL) || (tail_q != '0),
              "tail state with no results left")
  `CWA_ASSERT_NEXT(a_end_clear, (state_q == cwa_pkg::ST_UPDATE) && fin_q,
                   (sum_q == '0) && (count_q == '0) && (wp_q == '0),
                   "array state not cleared at end of array")

endmodule

### verif/window_average_checker.sv
// Result checker for the centered window average block: predicts every average from
// the accepted samples and radius writes, then compares each delivered result.
// Depends on cwa_pkg for the payload structs and sizes.
module window_average_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  cwa_pkg::in_t                     in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  cwa_pkg::out_t                    out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [cwa_pkg::RadiusBits-1:0]   cfg_data_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AvgLimit   = 2 ** cwa_pkg::SAMPLE_BITS - 1;
  localparam int ReportMax  = 10;

  // Predictor state
  logic [cwa_pkg::RadiusBits-1:0]  radius_q;
  logic [cwa_pkg::SAMPLE_BITS-1:0] delay_line [cwa_pkg::HistDepth];
  logic [cwa_pkg::SumBits-1:0]     run_sum;
  logic [cwa_pkg::CountBits-1:0]   sample_idx;
  logic [cwa_pkg::HistBits-1:0]    line_wr;

  cwa_pkg::out_t expected_avgs [$];
  int            mismatch_count = 0;
  int            result_count   = 0;
  int            pending_count  = 0;

  assign errors_o  = mismatch_count;
  assign pending_o = pending_count;
  assign results_o = result_count;

  // Count a failure; print only the first few
  function automatic void report_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  // Advance the window by one sample and queue the averages it releases
  task automatic predict_averages(input cwa_pkg::in_t item);
    logic [cwa_pkg::RadiusBits-1:0] k;
    logic [cwa_pkg::WinBits-1:0]    win;
    logic [cwa_pkg::CountBits-1:0]  j;
    logic [cwa_pkg::HistBits-1:0]   rd_addr;
    logic [cwa_pkg::SumBits-1:0]    quot;
    cwa_pkg::out_t                  res;
    logic                           has_avg;
    int                             tail;
    int                             total;
    int                             idx;
    // clamp the radius to the largest supported one
    k = radius_q;
    if (int'(k) > cwa_pkg::MAX_RADIUS) begin
      k = cwa_pkg::RadiusBits'(cwa_pkg::MAX_RADIUS);
    end
    win = {k, 1'b1};
    j   = sample_idx;

    // running sum: add the newcomer, drop the sample leaving the window
    run_sum = run_sum + item.sample;
    if (j >= win) begin
      rd_addr = line_wr - win;
      run_sum = run_sum - delay_line[rd_addr];
    end
    delay_line[line_wr] = item.sample;
    line_wr = line_wr + 1'b1;

    has_avg = (j >= k);
    tail    = 0;
    if (item.final_sample) begin
      tail = (int'(j) + 1 < int'(k)) ? int'(j) + 1 : int'(k);
    end
    total = (has_avg ? 1 : 0) + tail;
    idx   = 0;

    if (has_avg) begin
      if (j >= {k, 1'b0}) begin
        quot = run_sum / win;
        if (quot > AvgLimit) begin
          quot = cwa_pkg::SumBits'(AvgLimit);
        end
        res.average = quot[cwa_pkg::AvgBits-1:0];
      end else begin
        res.average = cwa_pkg::AvgNone;
      end
      res.end_of_run = item.final_sample && (idx == total - 1);
      expected_avgs.push_back(res);
      idx++;
    end

    // trailing positions whose window never completes
    for (int t = 0; t < tail; t++) begin
      res.average    = cwa_pkg::AvgNone;
      res.end_of_run = (idx == total - 1);
      expected_avgs.push_back(res);
      idx++;
    end

    if (item.final_sample) begin
      run_sum    = '0;
      sample_idx = '0;
      line_wr    = '0;
    end else if (sample_idx != cwa_pkg::CountMax) begin
      sample_idx = sample_idx + 1'b1;
    end
  endtask

  // Watch the three channels; a radius write applies to a sample taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    cwa_pkg::out_t want;
    if (!rst_ni) begin
      radius_q   = '0;
      run_sum    = '0;
      sample_idx = '0;
      line_wr    = '0;
      foreach (delay_line[i]) delay_line[i] = '0;
      expected_avgs.delete();
      pending_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        radius_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_averages(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        result_count++;
        if (expected_avgs.size() == 0) begin
          report_failure($sformatf("unexpected result average=%0d end_of_run=%0b",
                                   out_data_i.average, out_data_i.end_of_run));
        end else begin
          want = expected_avgs.pop_front();
          if (out_data_i.average !== want.average ||
              out_data_i.end_of_run !== want.end_of_run) begin
            report_failure($sformatf(
              "result %0d: expected average=%0d end_of_run=%0b, got average=%0d end_of_run=%0b",
              result_count, want.average, want.end_of_run,
              out_data_i.average, out_data_i.end_of_run));
          end
        end
      end
      pending_count = expected_avgs.size();
    end
  end

endmodule

### verif/centered_window_average_top_tb.sv
// Testbench top for the centered window average block: drives samples, radius
// writes and receiver stalls, and reports the verdict.
// Depends on cwa_pkg, centered_window_average_top and window_average_checker.
module centered_window_average_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 40;
  localparam int LongHold    = 300;
  localparam int RandomItems = 135;

  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SMALL, FILL_HIGH} fill_e;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  cwa_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_stall;
  cwa_pkg::out_t                  out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cwa_pkg::RadiusBits-1:0] cfg_data;

  int   errors;
  int   pending;
  int   results;
  int   samples_sent  = 0;
  int   arrays_sent   = 0;
  int   radius_writes = 0;
  int   burst_left    = 0;
  int   cur_radius    = 0;
  logic hold_req;
  logic hold_done;
  int   hold_left     = 0;
  int   run_left      = 0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  centered_window_average_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  window_average_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  // Receiver: runs of stall and free cycles, one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LongHold;
      hold_done <= 1'b1;
      run_left  <= 0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_stall <= 1'b0;
          run_left  <= $urandom_range(50, 200);
        end
        2, 3, 4, 5: begin
          out_stall <= 1'b0;
          run_left  <= $urandom_range(0, 5);
        end
        default: begin
          out_stall <= 1'b1;
          run_left  <= $urandom_range(0, 7);
        end
      endcase
    end
  end

  // Offer one sample and hold it until the transfer; gaps fall between bursts
  task automatic send_sample(input logic [cwa_pkg::SAMPLE_BITS-1:0] value, input logic last);
    in_valid <= 1'b1;
    in_data  <= '{sample: value, final_sample: last};
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (last) begin
      arrays_sent++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      in_data  <= cwa_pkg::in_t'($urandom);
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Send n samples of one fill pattern, closing the array if asked
  task automatic send_run(input int n, input fill_e fill, input logic closes);
    logic [cwa_pkg::SAMPLE_BITS-1:0] value;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_RANDOM:  value = cwa_pkg::SAMPLE_BITS'($urandom);
        FILL_EXTREME: value = $urandom_range(0, 1) ? '1 : '0;
        FILL_SMALL:   value = cwa_pkg::SAMPLE_BITS'($urandom_range(0, 15));
        default:      value = 16'hFFFF - cwa_pkg::SAMPLE_BITS'($urandom_range(0, 3));
      endcase
      send_sample(value, closes && (i == n - 1));
    end
  endtask

  // Drop valid and wait until every expected result has been delivered
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the radius through the configuration channel
  task automatic write_radius(input int k);
    cfg_valid <= 1'b1;
    cfg_data  <= cwa_pkg::RadiusBits'(k);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_radius = k;
    radius_writes++;
  endtask

  initial begin : stimulus
    int    n;
    int    split;
    int    random_start;
    logic  long_sent;
    fill_e fill;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    long_sent = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radius of zero: each average is the sample itself
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    drain_results();

    // widest window on a short array: only incomplete positions
    write_radius(cwa_pkg::MAX_RADIUS);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h3039, 1'b1);
    drain_results();

    // full-scale samples, then a single-sample array
    write_radius(1);
    repeat (4) send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0007, 1'b1);
    drain_results();

    // radius widened inside an array: the sum wraps and the mean saturates
    write_radius(0);
    repeat (5) send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    drain_results();
    write_radius(2);
    send_sample(16'h0000, 1'b1);
    drain_results();

    // radius narrowed inside an array: the stale sum saturates the mean
    repeat (5) send_sample(16'hFFFF, 1'b0);
    drain_results();
    write_radius(0);
    send_sample(16'h0000, 1'b1);

    // random phases, each with a fresh radius
    random_start = samples_sent;
    while (samples_sent < random_start + RandomItems) begin
      drain_results();
      case ($urandom_range(0, 4))
        0:       write_radius(0);
        1:       write_radius(cwa_pkg::MAX_RADIUS);
        2:       write_radius($urandom_range(1, 4));
        default: write_radius($urandom_range(0, cwa_pkg::MAX_RADIUS));
      endcase
      // one long array past the count saturation, with the receiver held off
      if (!long_sent) begin
        hold_req <= 1'b1;
        send_run($urandom_range(129, 131), FILL_RANDOM, 1'b1);
        long_sent = 1'b1;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          n    = $urandom_range(1, 2 * cur_radius + 8);
          fill = fill_e'($urandom_range(0, 3));
          if ($urandom_range(0, 5) == 0 && n > 1) begin
            split = $urandom_range(1, n - 1);
            send_run(split, fill, 1'b0);
            drain_results();
            write_radius($urandom_range(0, cwa_pkg::MAX_RADIUS));
            send_run(n - split, fill, 1'b1);
          end else begin
            send_run(n, fill, 1'b1);
          end
        end
      end
    end
    drain_results();

    $display("Covered %0d samples in %0d arrays over %0d radius writes (0 to %0d).",
             samples_sent, arrays_sent, radius_writes, cwa_pkg::MAX_RADIUS);
    $display("Compared %0d results; %0d mismatches, %0d still expected.",
             results, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("Timeout: stimulus or results did not complete");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/cwa_pkg.sv
src/cwa_ram.sv
src/centered_window_average_top.sv
verif/window_average_checker.sv
verif/centered_window_average_top_tb.sv
